// ----- sv/mhe_pkg.sv -----
// Shared types, constants and filter weight functions for the edge stream block.
// Depends on nothing; every other file refers to it by scoped names.
package mhe_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxRows   = 4096;
   localparam int HistDepth = 2 * MaxWidth + 4;
   localparam int AddrW     = $clog2(HistDepth);
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = 13;
   localparam int SRowW     = RowW + 1;
   localparam int WidthW    = 11;
   localparam int HeightW   = 13;
   localparam int ThrW      = 8;
   localparam int PixW      = 8;
   localparam int AccW      = 13;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 13;

   localparam logic [CsrIdxW-1:0] CsrThreshold = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrWidth     = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrHeight    = 2'd2;

   localparam logic [ThrW-1:0]    ThrReset    = 8'd20;
   localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
   localparam logic [HeightW-1:0] HeightReset = 13'd480;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVAL, ST_FT_RD, ST_FT_ACC, ST_SQ_X, ST_SQ_Y, ST_SQRT,
      ST_FT_WR, ST_Q_RD, ST_Q_LAT, ST_NB_RD, ST_NB_ACC, ST_OUT, ST_ADV
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic pix_wr;
      logic tap_clr;
      logic tap_rd;
      logic tap_acc;
      logic nb_mode;
      logic sq_x;
      logic sq_y;
      logic sqrt_step;
      logic filt_wr;
      logic q_rd;
      logic q_lat;
      logic out_load;
      logic step_adv;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic s_valid;
      logic q_valid;
      logic tap_last;
      logic sqrt_last;
      logic out_busy;
   } status_type;

   function automatic logic signed [3:0] lap_weight(input logic [1:0] r, input logic [1:0] c);
      logic signed [3:0] w;
      if (r == 2'd1 && c == 2'd1) w = -4'sd4;
      else if (r == 2'd1 || c == 2'd1) w = 4'sd1;
      else w = 4'sd0;
      return w;
   endfunction

   function automatic logic signed [3:0] sx_weight(input logic [1:0] r, input logic [1:0] c);
      logic signed [3:0] m;
      logic signed [3:0] w;
      m = (r == 2'd1) ? 4'sd2 : 4'sd1;
      if (c == 2'd0) w = m;
      else if (c == 2'd2) w = -m;
      else w = 4'sd0;
      return w;
   endfunction

   function automatic logic signed [3:0] sy_weight(input logic [1:0] r, input logic [1:0] c);
      logic signed [3:0] m;
      logic signed [3:0] w;
      m = (c == 2'd1) ? 4'sd2 : 4'sd1;
      if (r == 2'd0) w = m;
      else if (r == 2'd2) w = -m;
      else w = 4'sd0;
      return w;
   endfunction

endpackage

// ----- sv/mhe_ifs.sv -----
// Request, response and register write channels of the edge stream block.
// Depends on mhe_pkg for field widths.
interface mhe_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [mhe_pkg::PixW-1:0]  pixel_in;
   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface mhe_rsp_if;
   logic valid;
   logic ready;
   logic edge_flag;
   logic frame_last;
   modport source (output valid, output edge_flag, output frame_last, input ready);
   modport sink   (input valid, input edge_flag, input frame_last, output ready);
endinterface

interface mhe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mhe_pkg::CsrIdxW-1:0]   index;
   logic [mhe_pkg::CsrDataW-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mhe_ctrl.sv -----
// Sequencer of the edge stream block: walks one request through its steps.
// Depends on mhe_pkg for state, command and status types.
module mhe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhe_pkg::status_type status,
   output mhe_pkg::cmd_type    cmd
);

   mhe_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mhe_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mhe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = mhe_pkg::ST_EVAL;
            end
         end
         mhe_pkg::ST_EVAL: begin
            if (status.drop) state_in = mhe_pkg::ST_IDLE;
            else begin
               cmd.pix_wr  = 1'b1;
               cmd.tap_clr = 1'b1;
               if (status.s_valid) state_in = mhe_pkg::ST_FT_RD;
               else if (status.q_valid) state_in = mhe_pkg::ST_Q_RD;
               else state_in = mhe_pkg::ST_ADV;
            end
         end
         mhe_pkg::ST_FT_RD: begin
            cmd.tap_rd = 1'b1;
            state_in   = mhe_pkg::ST_FT_ACC;
         end
         mhe_pkg::ST_FT_ACC: begin
            cmd.tap_acc = 1'b1;
            state_in    = status.tap_last ? mhe_pkg::ST_SQ_X : mhe_pkg::ST_FT_RD;
         end
         mhe_pkg::ST_SQ_X: begin
            cmd.sq_x = 1'b1;
            state_in = mhe_pkg::ST_SQ_Y;
         end
         mhe_pkg::ST_SQ_Y: begin
            cmd.sq_y = 1'b1;
            state_in = mhe_pkg::ST_SQRT;
         end
         mhe_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) state_in = mhe_pkg::ST_FT_WR;
         end
         mhe_pkg::ST_FT_WR: begin
            cmd.filt_wr = 1'b1;
            state_in    = status.q_valid ? mhe_pkg::ST_Q_RD : mhe_pkg::ST_ADV;
         end
         mhe_pkg::ST_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = mhe_pkg::ST_Q_LAT;
         end
         mhe_pkg::ST_Q_LAT: begin
            cmd.q_lat   = 1'b1;
            cmd.tap_clr = 1'b1;
            state_in    = mhe_pkg::ST_NB_RD;
         end
         mhe_pkg::ST_NB_RD: begin
            cmd.tap_rd  = 1'b1;
            cmd.nb_mode = 1'b1;
            state_in    = mhe_pkg::ST_NB_ACC;
         end
         mhe_pkg::ST_NB_ACC: begin
            cmd.tap_acc = 1'b1;
            cmd.nb_mode = 1'b1;
            state_in    = status.tap_last ? mhe_pkg::ST_OUT : mhe_pkg::ST_NB_RD;
         end
         mhe_pkg::ST_OUT: begin
            // hold until the output slot is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               cmd.step_adv = 1'b1;
               state_in     = mhe_pkg::ST_IDLE;
            end
         end
         mhe_pkg::ST_ADV: begin
            cmd.step_adv = 1'b1;
            state_in     = mhe_pkg::ST_IDLE;
         end
         default: state_in = mhe_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- sv/mhe_datapath.sv -----
// Datapath of the edge stream block: registers, position counters, history
// memories, filter accumulators, square root and output slot. Uses mhe_pkg, mhe_ifs.
module mhe_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  mhe_pkg::cmd_type         cmd,
   output mhe_pkg::status_type      status,
   input  logic                     req_op,
   input  logic [mhe_pkg::PixW-1:0] req_pixel,
   mhe_csr_if.sink                  csr_ch,
   mhe_rsp_if.source                rsp_ch
);

   localparam int AW = mhe_pkg::AddrW;

   function automatic logic [AW-1:0] hist_back(input logic [AW-1:0] base, input logic [AW:0] k);
      logic [AW:0] d;
      logic [AW:0] dw;
      d  = {1'b0, base} - k;
      dw = d + (AW+1)'(mhe_pkg::HistDepth);
      return d[AW] ? dw[AW-1:0] : d[AW-1:0];
   endfunction

   // configuration
   logic [mhe_pkg::ThrW-1:0]    thr_ff;
   logic [mhe_pkg::WidthW-1:0]  width_ff;
   logic [mhe_pkg::HeightW-1:0] height_ff;
   logic [mhe_pkg::WidthW-1:0]  w_eff;
   logic [mhe_pkg::HeightW-1:0] h_eff;
   logic                        geom_wr;

   assign csr_ch.ready = 1'b1;
   assign geom_wr = csr_ch.valid &&
                    (csr_ch.index == mhe_pkg::CsrWidth || csr_ch.index == mhe_pkg::CsrHeight);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= mhe_pkg::ThrReset;
         width_ff  <= mhe_pkg::WidthReset;
         height_ff <= mhe_pkg::HeightReset;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            mhe_pkg::CsrThreshold: thr_ff    <= csr_ch.data[mhe_pkg::ThrW-1:0];
            mhe_pkg::CsrWidth:     width_ff  <= csr_ch.data[mhe_pkg::WidthW-1:0];
            mhe_pkg::CsrHeight:    height_ff <= csr_ch.data[mhe_pkg::HeightW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) w_eff = mhe_pkg::WidthW'(1);
      else if (width_ff > mhe_pkg::WidthW'(mhe_pkg::MaxWidth))
         w_eff = mhe_pkg::WidthW'(mhe_pkg::MaxWidth);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = mhe_pkg::HeightW'(1);
      else if (height_ff > mhe_pkg::HeightW'(mhe_pkg::MaxRows))
         h_eff = mhe_pkg::HeightW'(mhe_pkg::MaxRows);
      else h_eff = height_ff;
   end

   // stream position of the current request
   logic [mhe_pkg::ColW-1:0] in_col_ff;
   logic [mhe_pkg::RowW-1:0] in_row_ff;
   logic [AW-1:0]            ptr_t_ff;

   logic [mhe_pkg::WidthW-1:0]       w_m1;
   logic [mhe_pkg::ColW-1:0]         s_col_c, q_col_c;
   logic signed [mhe_pkg::SRowW-1:0] s_row_c, q_row_c, h_ext;
   logic [AW:0]                      w13;

   assign w_m1  = w_eff - mhe_pkg::WidthW'(1);
   assign w13   = (AW+1)'(w_eff);
   assign h_ext = $signed({1'b0, h_eff});

   // filter position sits one row and one pixel back, result position one more
   always_comb begin
      if (in_col_ff == '0) begin
         s_col_c = w_m1[mhe_pkg::ColW-1:0];
         s_row_c = $signed({1'b0, in_row_ff}) - $signed(mhe_pkg::SRowW'(2));
      end else begin
         s_col_c = in_col_ff - mhe_pkg::ColW'(1);
         s_row_c = $signed({1'b0, in_row_ff}) - $signed(mhe_pkg::SRowW'(1));
      end
      if (s_col_c == '0) begin
         q_col_c = w_m1[mhe_pkg::ColW-1:0];
         q_row_c = s_row_c - $signed(mhe_pkg::SRowW'(2));
      end else begin
         q_col_c = s_col_c - mhe_pkg::ColW'(1);
         q_row_c = s_row_c - $signed(mhe_pkg::SRowW'(1));
      end
   end

   // per-request latches
   logic                             op_ff, t_in_ff, s_valid_ff, q_valid_ff, q_last_ff;
   logic [mhe_pkg::PixW-1:0]         pix_ff;
   logic signed [mhe_pkg::SRowW-1:0] s_row_ff, q_row_ff;
   logic [mhe_pkg::ColW-1:0]         s_col_ff, q_col_ff;
   logic [AW-1:0]                    ptr_s_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff      <= req_op;
         pix_ff     <= req_pixel;
         s_row_ff   <= s_row_c;
         s_col_ff   <= s_col_c;
         q_row_ff   <= q_row_c;
         q_col_ff   <= q_col_c;
         t_in_ff    <= in_row_ff < h_eff;
         s_valid_ff <= !s_row_c[mhe_pkg::SRowW-1] && (s_row_c < h_ext);
         q_valid_ff <= !q_row_c[mhe_pkg::SRowW-1];
         q_last_ff  <= (q_row_c == $signed({1'b0, h_eff - mhe_pkg::HeightW'(1)})) &&
                       ({1'b0, q_col_c} == w_m1);
         ptr_s_ff   <= hist_back(ptr_t_ff, w13 + (AW+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geom_wr || (cmd.step_adv && q_valid_ff && q_last_ff)) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         ptr_t_ff  <= '0;
      end else if (cmd.step_adv) begin
         if ({1'b0, in_col_ff} == w_m1) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_ff + mhe_pkg::RowW'(1);
         end else in_col_ff <= in_col_ff + mhe_pkg::ColW'(1);
         if (ptr_t_ff == AW'(mhe_pkg::HistDepth - 1)) ptr_t_ff <= '0;
         else ptr_t_ff <= ptr_t_ff + AW'(1);
      end
   end

   // 3x3 tap walk
   logic [1:0] tap_r_ff, tap_c_ff;
   logic signed [mhe_pkg::SRowW-1:0]  base_row, xx;
   logic [mhe_pkg::ColW-1:0]          base_col;
   logic signed [mhe_pkg::ColW+1:0]   yy;
   logic                              in_img;
   logic [AW:0]                       kr, k_c;
   logic [AW-1:0]                     pix_addr, f_addr;

   always_comb begin
      base_row = cmd.nb_mode ? q_row_ff : s_row_ff;
      base_col = cmd.nb_mode ? q_col_ff : s_col_ff;
      xx = base_row + $signed({{(mhe_pkg::SRowW-2){1'b0}}, tap_r_ff})
                    - $signed(mhe_pkg::SRowW'(1));
      yy = $signed({2'b00, base_col}) + $signed({{mhe_pkg::ColW{1'b0}}, tap_c_ff})
           - $signed((mhe_pkg::ColW+2)'(1));
      in_img = !xx[mhe_pkg::SRowW-1] && (xx < h_ext) &&
               !yy[mhe_pkg::ColW+1] && (yy < $signed({1'b0, w_eff}));
      case (tap_r_ff)
         2'd0:    kr = w13 + w13 + (AW+1)'(1);
         2'd1:    kr = w13 + (AW+1)'(1);
         default: kr = (AW+1)'(1);
      endcase
      case (tap_c_ff)
         2'd0:    k_c = kr + (AW+1)'(1);
         2'd1:    k_c = kr;
         default: k_c = kr - (AW+1)'(1);
      endcase
      if (cmd.q_rd) k_c = w13 + (AW+1)'(1);
      pix_addr = hist_back(ptr_t_ff, k_c);
      f_addr   = hist_back(ptr_s_ff, k_c);
   end

   always_ff @(posedge clock) begin
      if (cmd.tap_clr) begin
         tap_r_ff <= '0;
         tap_c_ff <= '0;
      end else if (cmd.tap_acc) begin
         if (tap_c_ff == 2'd2) begin
            tap_c_ff <= '0;
            tap_r_ff <= tap_r_ff + 2'd1;
         end else tap_c_ff <= tap_c_ff + 2'd1;
      end
   end

   // history memories
   logic [mhe_pkg::PixW-1:0]   pix_mem [mhe_pkg::HistDepth];
   logic [2*mhe_pkg::PixW-1:0] f_mem   [mhe_pkg::HistDepth];
   logic [mhe_pkg::PixW-1:0]   pix_rd_ff;
   logic [2*mhe_pkg::PixW-1:0] f_rd_ff;
   logic                       in_img_ff;
   logic [mhe_pkg::PixW-1:0]   lap_res, root_ff;

   always_ff @(posedge clock) begin
      if (cmd.pix_wr && t_in_ff) pix_mem[ptr_t_ff] <= pix_ff;
      if (cmd.tap_rd || cmd.q_rd) pix_rd_ff <= pix_mem[pix_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.filt_wr) f_mem[ptr_s_ff] <= {lap_res, root_ff};
      if (cmd.tap_rd || cmd.q_rd) f_rd_ff <= f_mem[f_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.tap_rd) in_img_ff <= in_img;
   end

   // filter sums
   logic signed [mhe_pkg::AccW-1:0] sl_ff, sx_ff, sy_ff;
   logic signed [mhe_pkg::AccW-1:0] pl, px, py, sl_off, sxs, sys;
   logic signed [7:0]               gx, gy;
   logic signed [15:0]              gx_sq, gy_sq;
   logic [15:0]                     sumsq_ff, trial_sq;
   logic [2:0]                      bit_ff;
   logic [7:0]                      trial;

   always_comb begin
      pl = $signed({{(mhe_pkg::AccW-9){1'b0}}, 1'b0, pix_rd_ff})
           * mhe_pkg::lap_weight(tap_r_ff, tap_c_ff);
      px = $signed({{(mhe_pkg::AccW-9){1'b0}}, 1'b0, pix_rd_ff})
           * mhe_pkg::sx_weight(tap_r_ff, tap_c_ff);
      py = $signed({{(mhe_pkg::AccW-9){1'b0}}, 1'b0, pix_rd_ff})
           * mhe_pkg::sy_weight(tap_r_ff, tap_c_ff);
      sl_off = sl_ff + $signed(mhe_pkg::AccW'(128));
      if (sl_off < 0) lap_res = 8'd0;
      else if (sl_off > $signed(mhe_pkg::AccW'(255))) lap_res = 8'd255;
      else lap_res = sl_off[7:0];
      sxs = sx_ff >>> 2;
      sys = sy_ff >>> 2;
      if (sxs < $signed(-(mhe_pkg::AccW'(128)))) gx = -8'sd128;
      else if (sxs > $signed(mhe_pkg::AccW'(127))) gx = 8'sd127;
      else gx = sxs[7:0];
      if (sys < $signed(-(mhe_pkg::AccW'(128)))) gy = -8'sd128;
      else if (sys > $signed(mhe_pkg::AccW'(127))) gy = 8'sd127;
      else gy = sys[7:0];
      gx_sq    = gx * gx;
      gy_sq    = gy * gy;
      trial    = root_ff | (8'd1 << bit_ff);
      trial_sq = trial * trial;
   end

   always_ff @(posedge clock) begin
      if (cmd.tap_clr && !cmd.q_lat) begin
         sl_ff <= '0;
         sx_ff <= '0;
         sy_ff <= '0;
      end else if (cmd.tap_acc && !cmd.nb_mode && in_img_ff) begin
         sl_ff <= sl_ff + pl;
         sx_ff <= sx_ff + px;
         sy_ff <= sy_ff + py;
      end
      if (cmd.sq_x) begin
         sumsq_ff <= $unsigned(gx_sq);
         root_ff  <= '0;
         bit_ff   <= 3'd7;
      end else if (cmd.sq_y) sumsq_ff <= sumsq_ff + $unsigned(gy_sq);
      else if (cmd.sqrt_step) begin
         if (trial_sq <= sumsq_ff) root_ff <= trial;
         bit_ff <= bit_ff - 3'd1;
      end
   end

   // zero-crossing search
   logic [mhe_pkg::PixW-1:0] lap_q_ff, grad_q_ff, nb_v;
   logic                     hit_ff, above;

   assign nb_v  = f_rd_ff[2*mhe_pkg::PixW-1:mhe_pkg::PixW];
   assign above = lap_q_ff > 8'd128;

   always_ff @(posedge clock) begin
      if (cmd.q_lat) begin
         lap_q_ff  <= f_rd_ff[2*mhe_pkg::PixW-1:mhe_pkg::PixW];
         grad_q_ff <= f_rd_ff[mhe_pkg::PixW-1:0];
         hit_ff    <= 1'b0;
      end else if (cmd.tap_acc && cmd.nb_mode && in_img_ff) begin
         if (above ? (nb_v < 8'd128) : (nb_v > 8'd128)) hit_ff <= 1'b1;
      end
   end

   // output slot
   logic out_valid_ff, edge_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (rsp_ch.ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         edge_ff <= (grad_q_ff > thr_ff) && hit_ff;
         last_ff <= q_last_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.edge_flag  = edge_ff;
   assign rsp_ch.frame_last = last_ff;

   always_comb begin
      status.drop      = t_in_ff && op_ff;
      status.s_valid   = s_valid_ff;
      status.q_valid   = q_valid_ff;
      status.tap_last  = (tap_r_ff == 2'd2) && (tap_c_ff == 2'd2);
      status.sqrt_last = bit_ff == 3'd0;
      status.out_busy  = out_valid_ff && !rsp_ch.ready;
   end

endmodule

// ----- sv/marr_hildreth_edge_stream.sv -----
// Top level of the zero-crossing edge detector stream.
// Depends on mhe_pkg, mhe_ifs, mhe_ctrl and mhe_datapath.

// Grayscale pixels enter in raster order, one request each, and every result
// marks one pixel as edge or background, lagging the input by two rows plus
// two pixels; send flush requests (op = 1) after a frame's last pixel to drain
// the remaining results, the last one flagged frame_last. A dropped request
// (a flush inside a frame) ends in the evaluate step; one that both filters a
// pixel and emits a result reads each 3x3 window one tap at a time, a read and
// then an accumulate step per tap, through the single read port of each history
// memory (nine taps for the filters, nine for the zero-crossing search), and
// resolves the gradient square root one bit per cycle. Writing the frame width
// or height restarts the frame; register writes are taken every cycle.
module marr_hildreth_edge_stream (
   input  logic       clock,
   input  logic       reset,
   mhe_req_if.sink    req_ch,
   mhe_rsp_if.source  rsp_ch,
   mhe_csr_if.sink    csr_ch
);

   mhe_pkg::cmd_type    cmd;
   mhe_pkg::status_type status;
   logic                req_ready;
   logic                req_accept;

   // ready comes straight from the sequencer's idle state
   assign req_ch.ready = req_ready;
   assign req_accept   = req_ch.valid && req_ready;

   // sequencer: one request at a time
   mhe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: counters, history memories, filters and the output slot
   mhe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_op    (req_ch.op),
      .req_pixel (req_ch.pixel_in),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

   // a request is never taken on two consecutive edges
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ch.ready)
      else $error("request accepted while previous one still in work");

   // a new result never appears right after a request is taken
   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> !$past(req_accept))
      else $error("result loaded too early after a request");

endmodule
